### src/polytope_point_containment_distance_assert.svh
// assertion macros shared by the checker
`ifndef POLYTOPE_POINT_CONTAINMENT_DISTANCE_ASSERT_SVH
`define POLYTOPE_POINT_CONTAINMENT_DISTANCE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define PPCD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ppcd check failed");

// antecedent in one cycle implies consequent in the next
`define PPCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppcd check failed");

`endif

### src/ppcd_pkg.sv
package ppcd_pkg;

    // query point carried from front to back
    typedef struct packed {
        logic signed [23:0] z;
        logic signed [23:0] y;
        logic signed [23:0] x;
    } t_point;

    // one stored facet row
    typedef struct packed {
        logic [24:0]        inv;
        logic signed [23:0] bound;
        logic signed [15:0] cz;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } t_facet;

    // back-side status seen by the front
    typedef struct packed {
        logic queue_empty;
        logic back_busy;
    } t_drain;

    localparam int SL_W   = 43;
    localparam int HI_W   = 57;
    localparam int LO_W   = 56;
    localparam int DIST_W = 46;

    localparam logic [24:0] RECIP_ONE = 25'h1000000;

endpackage

### src/polytope_point_containment_distance.sv
// Polytope point containment and signed distance. A facet item (kind 0) loads
// one half-space into the table and returns nothing; it waits until queued
// queries have finished and then runs 3 squaring steps, 16 square-root steps,
// 25 division steps and the table write, skipping the division when the
// normal is all zero; full stays high until the table write is done.
// A query item (kind 1) returns one result once its facets_in_use table rows
// have been scanned: one table row is read per cycle through a five-stage
// slack and scaling pipeline. A two-entry queue holds queries between the
// accepting front and the computing back, and a finished result waits in its
// own register, so new items are taken while a result is still unread.
module polytope_point_containment_distance #(
    parameter int MAX_FACETS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic [3:0]         i_facet_slot,
    input  logic signed [15:0] i_coef_x,
    input  logic signed [15:0] i_coef_y,
    input  logic signed [15:0] i_coef_z,
    input  logic signed [23:0] i_offset,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [23:0] i_point_z,
    output logic               empty,
    input  logic               pop,
    output logic               o_inside_res,
    output logic signed [31:0] o_signed_distance,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);
    import ppcd_pkg::*;

    localparam int AW = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;

    logic [4:0]    r_facets_in_use;
    logic          q_push, q_full, q_pop, q_empty;
    t_point        q_in, q_out;
    t_drain        drain;
    logic          back_busy;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_facet        wr_data, rd_data;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facets_in_use <= 5'd0;
        end else if (i_cfg_we) begin
            r_facets_in_use <= i_cfg_data;
        end
    end

    assign drain.queue_empty = q_empty;
    assign drain.back_busy   = back_busy;

    ppcd_front #(.MAX_FACETS(MAX_FACETS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_kind       (i_kind),
        .i_facet_slot (i_facet_slot),
        .i_coef_x     (i_coef_x),
        .i_coef_y     (i_coef_y),
        .i_coef_z     (i_coef_z),
        .i_offset     (i_offset),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_q_push     (q_push),
        .o_q_data     (q_in),
        .i_q_full     (q_full),
        .i_drain      (drain),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    ppcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    ppcd_ram #(.WIDTH($bits(t_facet)), .DEPTH(MAX_FACETS)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ppcd_back #(.MAX_FACETS(MAX_FACETS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_facets_in_use   (r_facets_in_use),
        .i_q_data          (q_out),
        .i_q_empty         (q_empty),
        .o_q_pop           (q_pop),
        .o_busy            (back_busy),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr),
        .i_rd_data         (rd_data),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_inside_res      (o_inside_res),
        .o_signed_distance (o_signed_distance)
    );
endmodule

### src/ppcd_ram.sv
module ppcd_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### src/ppcd_queue.sv
module ppcd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppcd_pkg::t_point i_data,
    output logic            o_full,
    input  logic            i_pop,
    output ppcd_pkg::t_point o_data,
    output logic            o_empty
);
    import ppcd_pkg::*;

    t_point     r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr  = do_push ? ~r_wr : r_wr;
        n_rd  = do_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

### src/ppcd_front.sv
module ppcd_front #(
    parameter int MAX_FACETS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_kind,
    input  logic [3:0]            i_facet_slot,
    input  logic signed [15:0]    i_coef_x,
    input  logic signed [15:0]    i_coef_y,
    input  logic signed [15:0]    i_coef_z,
    input  logic signed [23:0]    i_offset,
    input  logic signed [23:0]    i_point_x,
    input  logic signed [23:0]    i_point_y,
    input  logic signed [23:0]    i_point_z,
    output logic                  o_q_push,
    output ppcd_pkg::t_point      o_q_data,
    input  logic                  i_q_full,
    input  ppcd_pkg::t_drain      i_drain,
    output logic                  o_wr_en,
    output logic [(MAX_FACETS > 1 ? $clog2(MAX_FACETS) : 1)-1:0] o_wr_addr,
    output ppcd_pkg::t_facet      o_wr_data
);
    import ppcd_pkg::*;

    localparam int AW = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_WAIT = 3'd1;
    localparam logic [2:0] F_SQ   = 3'd2;
    localparam logic [2:0] F_ROOT = 3'd3;
    localparam logic [2:0] F_DIV  = 3'd4;
    localparam logic [2:0] F_WR   = 3'd5;

    logic [2:0]         r_state;
    logic [3:0]         r_slot;
    logic signed [15:0] r_cx, r_cy, r_cz;
    logic signed [23:0] r_b;
    logic [1:0]         r_d;
    logic [31:0]        r_sq;
    logic [31:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_bit;
    logic [4:0]         r_it;
    logic [15:0]        r_div;
    logic [15:0]        r_drem;
    logic [24:0]        r_dvd;

    logic               accept;
    logic               slot_ok;
    logic signed [15:0] sel;
    logic signed [31:0] prod;
    logic [31:0]        sq_sum;
    logic [32:0]        trial;
    logic               take;
    logic [31:0]        n_rem, n_root;
    logic [16:0]        rem_sh;
    logic               ge;

    assign o_full  = (r_state != F_IDLE) || i_q_full;
    assign accept  = i_push && !o_full;
    assign slot_ok = ({5'd0, i_facet_slot} < 9'(MAX_FACETS));

    // queries go straight into the queue
    assign o_q_push   = accept && i_kind;
    assign o_q_data.x = i_point_x;
    assign o_q_data.y = i_point_y;
    assign o_q_data.z = i_point_z;

    // squared norm, one coefficient a cycle
    always_comb begin
        case (r_d)
            2'd0:    sel = r_cx;
            2'd1:    sel = r_cy;
            default: sel = r_cz;
        endcase
        prod   = sel * sel;
        sq_sum = r_sq + unsigned'(prod);
    end

    // restoring square root step
    always_comb begin
        trial  = {1'b0, r_root} + {1'b0, r_bit};
        take   = ({1'b0, r_rem} >= trial);
        n_rem  = take ? (r_rem - trial[31:0]) : r_rem;
        n_root = take ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    end

    // restoring division step
    always_comb begin
        rem_sh = {r_drem, r_dvd[24]};
        ge     = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept && !i_kind && slot_ok) begin
                        r_state <= F_WAIT;
                    end
                end
                F_WAIT: begin
                    if (i_drain.queue_empty && !i_drain.back_busy) begin
                        r_state <= F_SQ;
                    end
                end
                F_SQ: begin
                    if (r_d == 2'd2) begin
                        r_state <= F_ROOT;
                    end
                end
                F_ROOT: begin
                    if (r_it == 5'd15) begin
                        r_state <= (n_root == 32'd0) ? F_WR : F_DIV;
                    end
                end
                F_DIV: begin
                    if (r_it == 5'd24) begin
                        r_state <= F_WR;
                    end
                end
                F_WR: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // facet datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_slot <= i_facet_slot;
                r_cx   <= i_coef_x;
                r_cy   <= i_coef_y;
                r_cz   <= i_coef_z;
                r_b    <= i_offset;
                r_d    <= 2'd0;
                r_sq   <= 32'd0;
            end
            F_SQ: begin
                r_sq <= sq_sum;
                r_d  <= r_d + 2'd1;
                if (r_d == 2'd2) begin
                    r_rem  <= sq_sum;
                    r_root <= 32'd0;
                    r_bit  <= 32'h4000_0000;
                    r_it   <= 5'd0;
                end
            end
            F_ROOT: begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                if (r_it == 5'd15) begin
                    r_it   <= 5'd0;
                    r_div  <= n_root[15:0];
                    r_drem <= 16'd0;
                    if (n_root == 32'd0) begin
                        r_dvd <= 25'd0;
                    end else begin
                        r_dvd <= RECIP_ONE + 25'(n_root[15:1]);
                    end
                end else begin
                    r_it <= r_it + 5'd1;
                end
            end
            F_DIV: begin
                r_drem <= ge ? 16'(rem_sh - {1'b0, r_div}) : rem_sh[15:0];
                r_dvd  <= {r_dvd[23:0], ge};
                r_it   <= r_it + 5'd1;
            end
            default: begin
            end
        endcase
    end

    // table write
    assign o_wr_en         = (r_state == F_WR);
    assign o_wr_addr       = AW'({5'd0, r_slot});
    assign o_wr_data.inv   = r_dvd;
    assign o_wr_data.bound = r_b;
    assign o_wr_data.cx    = r_cx;
    assign o_wr_data.cy    = r_cy;
    assign o_wr_data.cz    = r_cz;
endmodule

### src/ppcd_back.sv
module ppcd_back #(
    parameter int MAX_FACETS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_facets_in_use,
    input  ppcd_pkg::t_point      i_q_data,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    output logic                  o_busy,
    output logic                  o_rd_en,
    output logic [(MAX_FACETS > 1 ? $clog2(MAX_FACETS) : 1)-1:0] o_rd_addr,
    input  ppcd_pkg::t_facet      i_rd_data,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic                  o_inside_res,
    output logic signed [31:0]    o_signed_distance
);
    import ppcd_pkg::*;

    localparam int AW = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
    localparam int CW = $clog2(MAX_FACETS + 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    localparam logic signed [DIST_W-1:0] DMIN32 = {{(DIST_W-31){1'b1}}, 31'd0};
    localparam logic signed [DIST_W-1:0] DMAX32 = {{(DIST_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [DIST_W-1:0] BEST_INIT = {1'b0, {(DIST_W-1){1'b1}}};

    logic [1:0]                r_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    t_point                    r_pt;
    logic                      r1_v, r2_v, r3_v, r4_v;
    logic signed [39:0]        r2_px, r2_py, r2_pz;
    logic signed [23:0]        r2_b;
    logic [24:0]               r2_inv, r3_inv;
    logic                      r2_zero, r3_zero, r4_zero;
    logic                      r3_bneg, r4_bneg, r2_bneg;
    logic signed [SL_W-1:0]    r3_slack;
    logic signed [HI_W-1:0]    r4_hi;
    logic signed [LO_W-1:0]    r4_lo;
    logic signed [DIST_W-1:0]  r_best;
    logic                      r_out_v;
    logic                      r_inside;
    logic signed [31:0]        r_dist;

    logic [8:0]                cfg_ext, cnt_clamp;
    logic                      issue;
    logic                      drained;
    logic signed [LO_W-1:0]    lo_sh;
    logic signed [HI_W:0]      acc;
    logic signed [HI_W:0]      acc_sh;
    logic signed [DIST_W-1:0]  scaled_dist;
    logic                      skip;

    assign cfg_ext   = {4'd0, i_facets_in_use};
    assign cnt_clamp = (cfg_ext > 9'(MAX_FACETS)) ? 9'(MAX_FACETS) : cfg_ext;

    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign issue     = (r_state == B_RUN) && (r_idx != r_count);
    assign drained   = !issue && !r1_v && !r2_v && !r3_v && !r4_v;
    assign o_rd_en   = issue;
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_busy    = (r_state != B_IDLE);

    // final stage: scaled slack and zero-normal handling
    always_comb begin
        lo_sh       = r4_lo >>> 12;
        acc         = (HI_W+1)'(r4_hi) + (HI_W+1)'(lo_sh);
        acc_sh      = acc >>> 12;
        scaled_dist = r4_zero ? DMIN32 : DIST_W'(acc_sh);
        skip        = r4_zero && !r4_bneg;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r1_v <= issue;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= B_RUN;
                    end
                end
                B_RUN: begin
                    if (drained) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (!r_out_v) begin
                        r_out_v <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // facet pipeline
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pt    <= i_q_data;
            r_count <= CW'(cnt_clamp);
            r_idx   <= '0;
            r_best  <= BEST_INIT;
        end
        if (issue) begin
            r_idx <= r_idx + CW'(1);
        end
        // products against the point
        r2_px   <= i_rd_data.cx * r_pt.x;
        r2_py   <= i_rd_data.cy * r_pt.y;
        r2_pz   <= i_rd_data.cz * r_pt.z;
        r2_b    <= i_rd_data.bound;
        r2_inv  <= i_rd_data.inv;
        r2_zero <= (i_rd_data.cx == 16'sd0) && (i_rd_data.cy == 16'sd0)
                   && (i_rd_data.cz == 16'sd0);
        r2_bneg <= i_rd_data.bound[23];
        // slack
        r3_slack <= (SL_W'(r2_b) <<< 12) - SL_W'(r2_px) - SL_W'(r2_py) - SL_W'(r2_pz);
        r3_inv   <= r2_inv;
        r3_zero  <= r2_zero;
        r3_bneg  <= r2_bneg;
        // reciprocal scaling split high and low
        r4_hi   <= r3_slack * $signed({1'b0, r3_inv[24:12]});
        r4_lo   <= r3_slack * $signed({1'b0, r3_inv[11:0]});
        r4_zero <= r3_zero;
        r4_bneg <= r3_bneg;
        // running minimum
        if (r4_v && !skip && (scaled_dist < r_best)) begin
            r_best <= scaled_dist;
        end
    end

    // saturate into the result register
    always_ff @(posedge i_clk) begin
        if ((r_state == B_DONE) && !r_out_v) begin
            r_inside <= !r_best[DIST_W-1];
            if (r_best > DMAX32) begin
                r_dist <= DMAX32[31:0];
            end else if (r_best < DMIN32) begin
                r_dist <= DMIN32[31:0];
            end else begin
                r_dist <= r_best[31:0];
            end
        end
    end

    assign o_empty           = !r_out_v;
    assign o_inside_res      = r_inside;
    assign o_signed_distance = r_dist;
endmodule

### src/ppcd_checker.sv
`include "polytope_point_containment_distance_assert.svh"

module ppcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               i_kind,
    input logic               empty,
    input logic               pop,
    input logic               o_inside_res,
    input logic signed [31:0] o_signed_distance
);
    // waiting result holds until taken
    `PPCD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_signed_distance) && $stable(o_inside_res))

    // inside flag agrees with the distance sign
    `PPCD_ASSERT_ALWAYS(a_inside, empty || (o_inside_res == !o_signed_distance[31]))

    // a facet beat keeps the input side busy for its load
    `PPCD_ASSERT_NEXT(a_facet_busy, push && !full && !i_kind, full)
endmodule

bind polytope_point_containment_distance ppcd_checker u_chk (.*);
